/* sv/kpt_pkg.sv */
// ----------------------------------------------------------------------------
// kpt_pkg
// Types and constants shared by the keyspace partition table modules.
// ----------------------------------------------------------------------------
package kpt_pkg;

	localparam int MAX_POSITIONS = 16;
	localparam int MAX_WORKERS   = 64;
	localparam int MAX_RADIX     = 256;

	localparam int POS_W  = 4;
	localparam int WRK_W  = 6;
	localparam int ADDR_W = POS_W + WRK_W;
	localparam int CELL_W = 25;
	localparam int DIV_NW = 12;
	localparam int DIV_DW = 9;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_BUILD = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic CFG_WORKER_REQUEST     = 1'b0;
	localparam logic CFG_START_FROM_INITIAL = 1'b1;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] position_index;
		logic [8:0] radix;
		logic [7:0] initial_index;
		logic [5:0] worker;
		logic [3:0] row;
	} cmd_t;

	typedef struct packed {
		logic [7:0] range_start;
		logic [7:0] range_stop;
		logic [8:0] start_index;
		logic       entry_valid;
		logic [6:0] active_workers;
		logic       status;
	} res_t;

	typedef struct packed {
		logic              go;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} mem_wr_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_QRD,
		ST_CHK,
		ST_COL,
		ST_ROW,
		ST_QR,
		ST_T,
		ST_TC,
		ST_VA,
		ST_VB,
		ST_WR,
		ST_LOGO,
		ST_LO,
		ST_HI,
		ST_AS,
		ST_BT,
		ST_CLR,
		ST_WB,
		ST_FIN
	} state_t;

endpackage

/* sv/keyspace_partition_table.sv */
// ----------------------------------------------------------------------------
// keyspace_partition_table
// Splits a mixed-radix keyspace into per-worker index ranges and serves
// the resulting table cell by cell.
//
// An item is taken when start is high and busy is low. Load items write one
// position and give no result. A query reads the range memory into the
// registered read port, and the ST_QRD state then registers the result on
// result with done high; a cell outside the table raises done straight from
// idle. A build checks the loaded positions (one per cycle), then computes
// each worker column row by row through the shared divider (two or three
// divisions per row while the worker still shares its range, none after),
// walks the start password per position when enabled and writes the column
// back, one row per cycle. Build time is set by that divider. Results are
// strobed on done for one cycle and cannot be held off. Configuration writes
// are taken at any clock edge with cfg_we high. Reset empties the loaded set
// and drops the table; the range memory is not cleared.
// ----------------------------------------------------------------------------
module keyspace_partition_table
	import kpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output res_t       result,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);

	state_t state_q, state_d;

	logic [4:0] n_q;
	logic [6:0] act_q;
	logic       ready_q;
	logic [6:0] want_q;
	logic       sfi_q;
	logic       done_q;
	res_t       res_q;

	logic [8:0] rad_q [MAX_POSITIONS];
	logic [7:0] req_q [MAX_POSITIONS];
	logic [7:0] lo_a  [MAX_POSITIONS];
	logic [7:0] hi_a  [MAX_POSITIONS];
	logic [8:0] bg_a  [MAX_POSITIONS];

	logic [4:0] p_q;
	logic       err_q;
	logic [6:0] perm_q;
	logic       dec_q;
	logic [6:0] actn_q;
	logic [6:0] col_q;
	logic [4:0] row_q;
	logic [4:0] pos_q;
	logic [6:0] g0_q;
	logic [6:0] cnt_q;
	logic [8:0] q_q;
	logic [8:0] r_q;
	logic [6:0] t_q;

	div_req_t          div_req;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;
	logic [DIV_DW-1:0] div_rem;
	mem_wr_t           mem_wr;
	logic              mem_re;
	logic [CELL_W-1:0] mem_rdata;

	logic [6:0]  wsat;
	logic [8:0]  rp;
	logic [15:0] prod;
	logic        act_cap;
	logic        err_p;
	logic        err_fin;
	logic        inrange;
	logic [3:0]  rix;
	logic [3:0]  pix;
	logic [8:0]  vals;
	logic [6:0]  ii;
	logic [6:0]  qp1;
	logic [7:0]  preq;
	logic [7:0]  plo;
	logic [7:0]  phi;

	kpt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	kpt_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.re    (mem_re),
		.raddr ({cmd.row, cmd.worker}),
		.rdata (mem_rdata)
	);

	assign wsat    = (want_q > 7'(MAX_WORKERS)) ? 7'(MAX_WORKERS) : want_q;
	assign rp      = rad_q[p_q[3:0]];
	assign prod    = {7'd0, rp} * {9'd0, perm_q};
	assign act_cap = (perm_q >= wsat) || (prod > {9'd0, wsat});
	assign err_p   = (rp == 9'd0) || (rp > 9'(MAX_RADIX))
		|| (sfi_q && ({1'b0, req_q[p_q[3:0]]} >= rp));
	assign err_fin = err_q || (want_q == 7'd0) || (n_q == 5'd0);
	assign inrange = ready_q && ({1'b0, cmd.worker} < act_q) && ({1'b0, cmd.row} < n_q);
	assign rix     = 4'(n_q - 5'd1 - row_q);
	assign pix     = 4'(n_q - 5'd1 - pos_q);
	assign vals    = rad_q[rix];
	assign ii      = col_q - g0_q;
	assign qp1     = 7'(q_q) + 7'd1;
	assign preq    = req_q[pos_q[3:0]];
	assign plo     = lo_a[pix];
	assign phi     = hi_a[pix];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && cmd.func == FUNC_BUILD) state_d = ST_CHK;
				else if (start && cmd.func == FUNC_QUERY && inrange) state_d = ST_QRD;
			end
			ST_QRD: state_d = ST_IDLE;
			ST_CHK: begin
				if (p_q == n_q) state_d = err_fin ? ST_IDLE : ST_COL;
			end
			ST_COL: state_d = ST_ROW;
			ST_ROW: begin
				if (row_q == n_q) state_d = sfi_q ? ST_AS : ST_WB;
				else if (cnt_q == 7'd1) state_d = ST_ROW;
				else if ({2'd0, cnt_q} >= vals) state_d = ST_QR;
				else state_d = ST_WR;
			end
			ST_QR: if (div_done) state_d = ST_T;
			ST_T: state_d = ST_TC;
			ST_TC: state_d = (ii < t_q) ? ST_VA : ST_VB;
			ST_VA: if (div_done) state_d = ST_ROW;
			ST_VB: if (div_done) state_d = ST_ROW;
			ST_WR: if (div_done) state_d = ST_LOGO;
			ST_LOGO: state_d = ST_LO;
			ST_LO: if (div_done) state_d = ST_HI;
			ST_HI: if (div_done) state_d = ST_ROW;
			ST_AS: begin
				if (pos_q == n_q) state_d = ST_WB;
				else if (preq < plo) state_d = ST_WB;
				else if (preq <= phi) state_d = ST_AS;
				else if (pos_q == 5'd0) state_d = ST_WB;
				else state_d = ST_BT;
			end
			ST_BT: begin
				if (preq < phi) state_d = ST_CLR;
				else if (pos_q == 5'd0) state_d = ST_WB;
			end
			ST_CLR: if (pos_q == n_q) state_d = ST_WB;
			ST_WB: begin
				if (row_q == n_q - 5'd1) state_d = (col_q + 7'd1 == actn_q) ? ST_FIN : ST_COL;
			end
			ST_FIN: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		busy        = state_q != ST_IDLE;
		div_req     = '0;
		mem_re      = (state_q == ST_IDLE) && start && (cmd.func == FUNC_QUERY) && inrange;
		mem_wr.we   = state_q == ST_WB;
		mem_wr.addr = {row_q[3:0], col_q[5:0]};
		mem_wr.data = {lo_a[row_q[3:0]], hi_a[row_q[3:0]], bg_a[row_q[3:0]]};
		unique case (state_q)
			ST_ROW: begin
				if (row_q != n_q && cnt_q != 7'd1) begin
					div_req.go = 1'b1;
					if ({2'd0, cnt_q} >= vals) begin
						div_req.num = DIV_NW'(cnt_q);
						div_req.den = vals;
					end else begin
						div_req.num = DIV_NW'(vals);
						div_req.den = DIV_DW'(cnt_q);
					end
				end
			end
			ST_TC: begin
				div_req.go = 1'b1;
				if (ii < t_q) begin
					div_req.num = DIV_NW'(ii);
					div_req.den = DIV_DW'(qp1);
				end else begin
					div_req.num = DIV_NW'(ii - t_q);
					div_req.den = q_q;
				end
			end
			ST_LOGO: begin
				div_req.go  = 1'b1;
				div_req.num = DIV_NW'({9'd0, ii} * {7'd0, r_q});
				div_req.den = DIV_DW'(cnt_q);
			end
			ST_LO: begin
				if (div_done) begin
					div_req.go  = 1'b1;
					div_req.num = DIV_NW'({9'd0, ii + 7'd1} * {7'd0, r_q});
					div_req.den = DIV_DW'(cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			act_q   <= '0;
			ready_q <= 1'b0;
			want_q  <= 7'd1;
			sfi_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_WORKER_REQUEST) want_q <= cfg_data;
				else sfi_q <= cfg_data[0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start && cmd.func == FUNC_LOAD) begin
						if ({1'b0, cmd.position_index} >= n_q) n_q <= 5'(cmd.position_index) + 5'd1;
						ready_q <= 1'b0;
						act_q   <= '0;
					end
					if (start && cmd.func == FUNC_QUERY && !inrange) done_q <= 1'b1;
				end
				ST_QRD: done_q <= 1'b1;
				ST_CHK: if (p_q == n_q && err_fin) done_q <= 1'b1;
				ST_FIN: begin
					done_q  <= 1'b1;
					act_q   <= actn_q;
					ready_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				p_q    <= '0;
				err_q  <= 1'b0;
				perm_q <= 7'd1;
				dec_q  <= 1'b0;
				res_q  <= '0;
				res_q.active_workers <= act_q;
				if (start && cmd.func == FUNC_LOAD) begin
					rad_q[cmd.position_index] <= cmd.radix;
					req_q[cmd.position_index] <= cmd.initial_index;
				end
			end
			ST_QRD: begin
				res_q.range_start <= mem_rdata[24:17];
				res_q.range_stop  <= mem_rdata[16:9];
				res_q.start_index <= mem_rdata[8:0];
				res_q.entry_valid <= 1'b1;
			end
			ST_CHK: begin
				if (p_q == n_q) begin
					actn_q <= dec_q ? actn_q : perm_q;
					col_q  <= '0;
					res_q.status <= err_fin;
					res_q.active_workers <= '0;
				end else begin
					p_q <= p_q + 5'd1;
					if (err_p) err_q <= 1'b1;
					if (!dec_q) begin
						if (act_cap) begin
							actn_q <= wsat;
							dec_q  <= 1'b1;
						end else begin
							perm_q <= 7'(prod);
						end
					end
				end
			end
			ST_COL: begin
				g0_q  <= '0;
				cnt_q <= actn_q;
				row_q <= '0;
			end
			ST_ROW: begin
				if (row_q == n_q) begin
					row_q <= '0;
					pos_q <= '0;
				end else if (cnt_q == 7'd1) begin
					// single worker here: it takes the whole row
					lo_a[row_q[3:0]] <= '0;
					hi_a[row_q[3:0]] <= 8'(vals - 9'd1);
					bg_a[row_q[3:0]] <= '0;
					row_q <= row_q + 5'd1;
				end
			end
			ST_QR, ST_WR: begin
				if (div_done) begin
					q_q <= div_quo[8:0];
					r_q <= div_rem;
				end
			end
			ST_T: t_q <= 7'({7'd0, r_q} * {9'd0, qp1});
			ST_VA: begin
				if (div_done) begin
					lo_a[row_q[3:0]] <= 8'(div_quo);
					hi_a[row_q[3:0]] <= 8'(div_quo);
					bg_a[row_q[3:0]] <= 9'(div_quo);
					g0_q  <= g0_q + 7'({7'd0, 7'(div_quo)} * {7'd0, qp1});
					cnt_q <= qp1;
					row_q <= row_q + 5'd1;
				end
			end
			ST_VB: begin
				if (div_done) begin
					lo_a[row_q[3:0]] <= 8'(r_q) + 8'(div_quo);
					hi_a[row_q[3:0]] <= 8'(r_q) + 8'(div_quo);
					bg_a[row_q[3:0]] <= r_q + 9'(div_quo);
					g0_q  <= g0_q + t_q + 7'({7'd0, 7'(div_quo)} * {7'd0, 7'(q_q)});
					cnt_q <= 7'(q_q);
					row_q <= row_q + 5'd1;
				end
			end
			ST_LO: begin
				if (div_done) begin
					lo_a[row_q[3:0]] <= 8'({9'd0, ii} * {7'd0, q_q} + 16'(div_quo));
					bg_a[row_q[3:0]] <= 9'({9'd0, ii} * {7'd0, q_q} + 16'(div_quo));
				end
			end
			ST_HI: begin
				if (div_done) begin
					hi_a[row_q[3:0]] <=
						8'({9'd0, ii + 7'd1} * {7'd0, q_q} + 16'(div_quo) - 16'd1);
					cnt_q <= 7'd1;
					row_q <= row_q + 5'd1;
				end
			end
			ST_AS: begin
				if (pos_q != n_q && preq >= plo) begin
					if (preq <= phi) begin
						bg_a[pix] <= 9'(preq);
						pos_q <= pos_q + 5'd1;
					end else if (pos_q == 5'd0) begin
						bg_a[pix] <= 9'(phi) + 9'd1;
					end else begin
						pos_q <= pos_q - 5'd1;
					end
				end
			end
			ST_BT: begin
				// back up to the nearest outer position that can still advance
				if (preq < phi) begin
					bg_a[pix] <= 9'(preq) + 9'd1;
					pos_q <= pos_q + 5'd1;
				end else if (pos_q == 5'd0) begin
					bg_a[pix] <= 9'(phi) + 9'd1;
				end else begin
					pos_q <= pos_q - 5'd1;
				end
			end
			ST_CLR: begin
				if (pos_q != n_q) begin
					bg_a[pix] <= 9'(plo);
					pos_q <= pos_q + 5'd1;
				end
			end
			ST_WB: begin
				if (row_q == n_q - 5'd1) begin
					col_q <= col_q + 7'd1;
				end else begin
					row_q <= row_q + 5'd1;
				end
			end
			ST_FIN: begin
				res_q.status         <= 1'b0;
				res_q.entry_valid    <= 1'b1;
				res_q.active_workers <= actn_q;
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

/* sv/kpt_div.sv */
// ----------------------------------------------------------------------------
// kpt_div
// Restoring divider, one quotient bit per cycle, shared by the build pass.
// ----------------------------------------------------------------------------
module kpt_div
	import kpt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [DIV_NW-1:0] quo,
	output logic [DIV_DW-1:0] rem
);

	logic              run_q;
	logic              done_q;
	logic [3:0]        step_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW:0]   rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW:0]   diff;
	logic              ge;

	assign shifted = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'(DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], ge};
			rem_q <= ge ? diff : shifted;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[DIV_DW-1:0];

endmodule

/* sv/kpt_mem.sv */
// ----------------------------------------------------------------------------
// kpt_mem
// Range table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kpt_mem
	import kpt_pkg::*;
(
	input  logic              clk,
	input  mem_wr_t           wr,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [2**ADDR_W];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
